### sv/bbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
endpackage
`default_nettype wire

### sv/bbc_ext.sv
`timescale 1ns / 1ps
`default_nettype none
module bbc_ext #(
  parameter int FRAC_BITS   = bbc_pkg::FRAC_BITS,
  parameter int COORD_WIDTH = bbc_pkg::COORD_WIDTH,
  localparam int R  = FRAC_BITS + 2,
  localparam int HW = COORD_WIDTH - 1,
  localparam int PW = R + HW + 1,
  localparam int XW = PW + 1,
  localparam int EW = ((XW > COORD_WIDTH + FRAC_BITS) ? XW : COORD_WIDTH + FRAC_BITS) + 1
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire logic signed [COORD_WIDTH-1:0] cx,
  input  wire logic signed [COORD_WIDTH-1:0] cy,
  input  wire logic signed [R-1:0]     cs,
  input  wire logic signed [R-1:0]     sn,
  input  wire logic [HW-1:0]           hw,
  input  wire logic [HW-1:0]           hh,
  output logic signed [EW-1:0]         lo_x,
  output logic signed [EW-1:0]         hi_x,
  output logic signed [EW-1:0]         lo_y,
  output logic signed [EW-1:0]         hi_y
);
  logic signed [PW-1:0] p_cw, p_sh, p_sw, p_ch;
  logic signed [COORD_WIDTH-1:0] cx1, cy1, cx2, cy2;
  logic signed [XW-1:0] ex2, ey2;
  logic signed [EW-1:0] cxs, cys, a0, a1, b0, b1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cw <= cs * $signed({1'b0, hw});
      p_sh <= sn * $signed({1'b0, hh});
      p_sw <= sn * $signed({1'b0, hw});
      p_ch <= cs * $signed({1'b0, hh});
      cx1  <= cx;
      cy1  <= cy;
      ex2  <= p_cw - p_sh;
      ey2  <= p_sw + p_ch;
      cx2  <= cx1;
      cy2  <= cy1;
      lo_x <= (a0 < a1) ? a0 : a1;
      hi_x <= (a0 < a1) ? a1 : a0;
      lo_y <= (b0 < b1) ? b0 : b1;
      hi_y <= (b0 < b1) ? b1 : b0;
    end
  end

  always_comb begin
    cxs = $signed({cx2, {FRAC_BITS{1'b0}}});
    cys = $signed({cy2, {FRAC_BITS{1'b0}}});
    a0  = cxs - ex2;
    a1  = cxs + ex2;
    b0  = cys - ey2;
    b1  = cys + ey2;
  end
endmodule
`default_nettype wire

### sv/box_box_collision_2d_top.sv
// throughput: one box pair per cycle, set by the five-stage multiply pipeline,
// unless the output stalls; a stalled output word holds every stage in place
// reset: rst clears the stage valid bits only, no data registers are reset
`timescale 1ns / 1ps
`default_nettype none
module box_box_collision_2d_top #(
  parameter int FRAC_BITS   = bbc_pkg::FRAC_BITS,
  parameter int COORD_WIDTH = bbc_pkg::COORD_WIDTH,
  localparam int R   = FRAC_BITS + 2,
  localparam int W   = COORD_WIDTH,
  localparam int HW  = COORD_WIDTH - 1,
  localparam int IB  = 4 * W + 4 * R + 4 * HW,
  localparam int IBW = ((IB + 7) / 8) * 8,
  localparam int OB  = 1 + HW + 2 * R + 2 * W,
  localparam int OBW = ((OB + 7) / 8) * 8
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            s_tvalid,
  output logic           s_tready,
  // src cx, cy, cos, sin, half_w, half_h, dst cx, cy, cos, sin, half_w, half_h
  input  wire [IBW-1:0]  s_tdata,
  output logic           m_tvalid,
  input  wire            m_tready,
  // hit, depth, normal_x, normal_y, contact_x, contact_y
  output logic [OBW-1:0] m_tdata
);
  localparam int PR  = 2 * R;
  localparam int MW  = PR + 1 - FRAC_BITS;
  localparam int TW  = ((MW + HW > HW + FRAC_BITS) ? MW + HW : HW + FRAC_BITS) + 2;
  localparam int QP  = W + R + 1;
  localparam int CPW = W + R + 2;
  localparam int XW  = R + HW + 2;
  localparam int EW  = ((XW > W + FRAC_BITS) ? XW : W + FRAC_BITS) + 1;
  localparam int BO  = 2 * W + 2 * R + 2 * HW;
  localparam int OW  = TW - FRAC_BITS;
  localparam int SW  = EW + 1 - FRAC_BITS;
  localparam int MSW = EW + 1 - (FRAC_BITS + 1);

  logic en;
  logic v1, v2, v3, v4;

  logic signed [W-1:0] scx, scy, dcx, dcy;
  logic signed [R-1:0] sc, ss, dc, ds;
  logic [HW-1:0] shw, shh, dhw, dhh;

  assign scx = s_tdata[0 +: W];
  assign scy = s_tdata[W +: W];
  assign sc  = s_tdata[2*W +: R];
  assign ss  = s_tdata[2*W+R +: R];
  assign shw = s_tdata[2*W+2*R +: HW];
  assign shh = s_tdata[2*W+2*R+HW +: HW];
  assign dcx = s_tdata[BO +: W];
  assign dcy = s_tdata[BO+W +: W];
  assign dc  = s_tdata[BO+2*W +: R];
  assign ds  = s_tdata[BO+2*W+R +: R];
  assign dhw = s_tdata[BO+2*W+2*R +: HW];
  assign dhh = s_tdata[BO+2*W+2*R+HW +: HW];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1
  logic signed [W:0] clx1, cly1;
  logic signed [PR-1:0] pa1, pa2, pb1, pb2;
  logic signed [R-1:0] sc1, ss1, dc1, ds1;
  logic [HW-1:0] shw1, shh1, dhw1, dhh1;
  logic al1, ltx1, lty1;

  // stage 2
  logic [MW-1:0] ma2, mb2, mbn2;
  logic signed [QP-1:0] q2 [8];
  logic signed [R-1:0] sc2, ss2, dc2, ds2;
  logic [HW-1:0] shw2, shh2, dhw2, dhh2;
  logic al2, ltx2, lty2;
  logic signed [PR:0] av, bv, bn;
  logic signed [MW-1:0] fa, fb, fbn;

  // stage 3
  logic signed [CPW-1:0] dot3 [4];
  logic [MW+HW-1:0] t3 [8];
  logic [HW-1:0] hf3 [4];
  logic signed [R-1:0] sc3, ss3, dc3, ds3;
  logic al3, ltx3, lty3;
  logic signed [EW-1:0] slx, shx, sly, shy, dlx, dhx, dly, dhy;

  // stage 4
  logic [TW-1:0] ov4 [4];
  logic ok4, pos4 [4];
  logic signed [EW-1:0] ilx4, ihx4, ily4, ihy4;
  logic amiss4;
  logic signed [R-1:0] sc4, ss4, dc4, ds4;
  logic al4, ltx4, lty4;
  logic [TW-1:0] tot [4];
  logic [CPW-1:0] cpm [4];
  logic ok_c [4];
  logic signed [EW-1:0] ilx, ihx, ily, ihy;

  // stage 5
  logic signed [EW:0] ox, oy, sx, sy;
  logic [1:0] best;
  logic [TW-1:0] bov;
  logic signed [R-1:0] nx, ny, axx [4], axy [4];
  logic [HW-1:0] dep;
  logic hit;
  logic [OW-1:0] ovs;
  logic signed [SW-1:0] ads;
  logic signed [MSW-1:0] msx, msy;
  logic signed [W-1:0] ctx, cty;
  logic [OB-1:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clx1 <= $signed({scx[W-1], scx}) - $signed({dcx[W-1], dcx});
      cly1 <= $signed({scy[W-1], scy}) - $signed({dcy[W-1], dcy});
      pa1  <= sc * dc;
      pa2  <= ss * ds;
      pb1  <= sc * ds;
      pb2  <= ss * dc;
      sc1  <= sc;
      ss1  <= ss;
      dc1  <= dc;
      ds1  <= ds;
      shw1 <= shw;
      shh1 <= shh;
      dhw1 <= dhw;
      dhh1 <= dhh;
      al1  <= (sc == R'(1 << FRAC_BITS)) && (ss == '0) &&
              (dc == R'(1 << FRAC_BITS)) && (ds == '0);
      ltx1 <= scx < dcx;
      lty1 <= scy < dcy;
    end
  end

  always_comb begin
    av  = pa1 + pa2;
    bv  = pb2 - pb1;
    bn  = pb1 - pb2;
    fa  = MW'(av >>> FRAC_BITS);
    fb  = MW'(bv >>> FRAC_BITS);
    fbn = MW'(bn >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma2  <= fa[MW-1] ? -fa : fa;
      mb2  <= fb[MW-1] ? -fb : fb;
      mbn2 <= fbn[MW-1] ? -fbn : fbn;
      q2[0] <= clx1 * sc1;
      q2[1] <= cly1 * ss1;
      q2[2] <= cly1 * sc1;
      q2[3] <= clx1 * ss1;
      q2[4] <= clx1 * dc1;
      q2[5] <= cly1 * ds1;
      q2[6] <= cly1 * dc1;
      q2[7] <= clx1 * ds1;
      sc2  <= sc1;
      ss2  <= ss1;
      dc2  <= dc1;
      ds2  <= ds1;
      shw2 <= shw1;
      shh2 <= shh1;
      dhw2 <= dhw1;
      dhh2 <= dhh1;
      al2  <= al1;
      ltx2 <= ltx1;
      lty2 <= lty1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot3[0] <= CPW'(q2[0]) + CPW'(q2[1]);
      dot3[1] <= CPW'(q2[2]) - CPW'(q2[3]);
      dot3[2] <= CPW'(q2[4]) + CPW'(q2[5]);
      dot3[3] <= CPW'(q2[6]) - CPW'(q2[7]);
      t3[0] <= ma2 * dhw2;
      t3[1] <= mb2 * dhh2;
      t3[2] <= mbn2 * dhw2;
      t3[3] <= ma2 * dhh2;
      t3[4] <= ma2 * shw2;
      t3[5] <= mbn2 * shh2;
      t3[6] <= mb2 * shw2;
      t3[7] <= ma2 * shh2;
      hf3[0] <= shw2;
      hf3[1] <= shh2;
      hf3[2] <= dhw2;
      hf3[3] <= dhh2;
      sc3  <= sc2;
      ss3  <= ss2;
      dc3  <= dc2;
      ds3  <= ds2;
      al3  <= al2;
      ltx3 <= ltx2;
      lty3 <= lty2;
    end
  end

  bbc_ext #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_src_ext (
    .clk(clk), .en(en), .cx(scx), .cy(scy), .cs(sc), .sn(ss), .hw(shw), .hh(shh),
    .lo_x(slx), .hi_x(shx), .lo_y(sly), .hi_y(shy)
  );

  bbc_ext #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_dst_ext (
    .clk(clk), .en(en), .cx(dcx), .cy(dcy), .cs(dc), .sn(ds), .hw(dhw), .hh(dhh),
    .lo_x(dlx), .hi_x(dhx), .lo_y(dly), .hi_y(dhy)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tot[k]  = TW'({hf3[k], {FRAC_BITS{1'b0}}}) + TW'(t3[2*k]) + TW'(t3[2*k+1]);
      cpm[k]  = dot3[k][CPW-1] ? -dot3[k] : dot3[k];
      ok_c[k] = tot[k] > TW'(cpm[k]);
    end
    ilx = (slx > dlx) ? slx : dlx;
    ihx = (shx < dhx) ? shx : dhx;
    ily = (sly > dly) ? sly : dly;
    ihy = (shy < dhy) ? shy : dhy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ov4[k]  <= tot[k] - TW'(cpm[k]);
        pos4[k] <= !dot3[k][CPW-1] && (dot3[k] != '0);
      end
      ok4    <= ok_c[0] && ok_c[1] && ok_c[2] && ok_c[3];
      amiss4 <= (slx > dhx) || (shx < dlx) || (sly > dhy) || (shy < dly);
      ilx4 <= ilx;
      ihx4 <= ihx;
      ily4 <= ily;
      ihy4 <= ihy;
      sc4  <= sc3;
      ss4  <= ss3;
      dc4  <= dc3;
      ds4  <= ds3;
      al4  <= al3;
      ltx4 <= ltx3;
      lty4 <= lty3;
    end
  end

  always_comb begin
    axx[0] = sc4;
    axy[0] = ss4;
    axx[1] = -ss4;
    axy[1] = sc4;
    axx[2] = dc4;
    axy[2] = ds4;
    axx[3] = -ds4;
    axy[3] = dc4;
    best = 2'd0;
    bov  = ov4[0];
    for (int k = 1; k < 4; k++) begin
      if (ov4[k] < bov) begin
        best = 2'(k);
        bov  = ov4[k];
      end
    end
    ox = $signed({ihx4[EW-1], ihx4}) - $signed({ilx4[EW-1], ilx4});
    oy = $signed({ihy4[EW-1], ihy4}) - $signed({ily4[EW-1], ily4});
    sx = $signed({ihx4[EW-1], ihx4}) + $signed({ilx4[EW-1], ilx4});
    sy = $signed({ihy4[EW-1], ihy4}) + $signed({ily4[EW-1], ily4});
    ovs = bov[TW-1:FRAC_BITS];
    ads = '0;
    nx  = '0;
    ny  = '0;
    dep = '0;
    if (al4) begin
      hit = !amiss4;
      if (ox < oy) begin
        ads = SW'(ox >>> FRAC_BITS);
        nx  = ltx4 ? R'(1 << FRAC_BITS) : -R'(1 << FRAC_BITS);
      end else begin
        ads = SW'(oy >>> FRAC_BITS);
        ny  = lty4 ? R'(1 << FRAC_BITS) : -R'(1 << FRAC_BITS);
      end
      if (ads[SW-1]) begin
        dep = '0;
      end else if (ads[SW-2:HW] != '0) begin
        dep = '1;
      end else begin
        dep = ads[HW-1:0];
      end
    end else begin
      hit = ok4;
      nx  = pos4[best] ? -axx[best] : axx[best];
      ny  = pos4[best] ? -axy[best] : axy[best];
      dep = (ovs[OW-1:HW] != '0) ? '1 : ovs[HW-1:0];
    end
    msx = MSW'(sx >>> (FRAC_BITS + 1));
    msy = MSW'(sy >>> (FRAC_BITS + 1));
    if (msx[MSW-1:W-1] == '0 || msx[MSW-1:W-1] == '1) begin
      ctx = msx[W-1:0];
    end else begin
      ctx = msx[MSW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    if (msy[MSW-1:W-1] == '0 || msy[MSW-1:W-1] == '1) begin
      cty = msy[W-1:0];
    end else begin
      cty = msy[MSW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    res = hit ? {cty, ctx, ny, nx, dep, 1'b1} : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OBW'(res);
    end
  end

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OBW-1:1] == '0)
    else $error("miss word carries nonzero fields");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !v1 && !v4)
    else $error("pipeline not empty after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v1) && $stable(v2) && $stable(v3) && $stable(v4))
    else $error("stage valid moved during stall");
`endif
endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int FB  = bbc_pkg::FRAC_BITS;
  localparam int R   = FB + 2;
  localparam int W   = bbc_pkg::COORD_WIDTH;
  localparam int HW  = W - 1;
  localparam int IB  = 4 * W + 4 * R + 4 * HW;
  localparam int IBW = ((IB + 7) / 8) * 8;
  localparam int OB  = 1 + HW + 2 * R + 2 * W;
  localparam int OBW = ((OB + 7) / 8) * 8;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint DEPTH_MAX = (64'sd1 <<< HW) - 1;
  localparam longint CMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (W - 1));
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [HW-1:0] hh;
    logic [HW-1:0] hw;
    logic [R-1:0]  sn;
    logic [R-1:0]  cs;
    logic [W-1:0]  cy;
    logic [W-1:0]  cx;
  } box_t;

  typedef struct packed {
    logic [W-1:0]  contact_y;
    logic [W-1:0]  contact_x;
    logic [R-1:0]  normal_y;
    logic [R-1:0]  normal_x;
    logic [HW-1:0] depth;
    logic          hit;
  } hit_t;

  typedef struct {
    longint cx, cy, axx, axy, ayx, ayy, hw, hh;
  } obb_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IBW-1:0] s_tdata;
  logic [OBW-1:0] m_tdata;

  box_box_collision_2d_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  hit_t expected_hits[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint fl(longint v, int s);
    if (v < 0) return ~((~v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic obb_t unpack_box(box_t b);
    obb_t o;
    longint c, s;
    c = longint'($signed(b.cs));
    s = longint'($signed(b.sn));
    o.cx = longint'($signed(b.cx));
    o.cy = longint'($signed(b.cy));
    o.axx = c; o.axy = s; o.ayx = -s; o.ayy = c;
    o.hw = longint'(b.hw);
    o.hh = longint'(b.hh);
    return o;
  endfunction

  function automatic bit axis_gap(longint clx, longint cly, longint ax, longint ay,
                                  longint own, obb_t o, output longint ov);
    longint cp, dx, dy, tot;
    cp = absv(clx * ax + cly * ay);
    dx = absv(fl(ax * o.axx + ay * o.axy, FB));
    dy = absv(fl(ax * o.ayx + ay * o.ayy, FB));
    tot = own * ONE + dx * o.hw + dy * o.hh;
    ov = tot - cp;
    return tot > cp;
  endfunction

  function automatic hit_t predict_contact(box_t sb, box_t db);
    obb_t s, d;
    hit_t r;
    longint slo[2], shi[2], dlo[2], dhi[2], ilo[2], ihi[2];
    longint e, c, a0, a1, depth, nx, ny, ox, oy, clx, cly;
    longint ov[4], axx[4], axy[4];
    int best;
    s = unpack_box(sb);
    d = unpack_box(db);
    r = '0;
    for (int i = 0; i < 2; i++) begin
      e = (i == 0) ? s.axx * s.hw + s.ayx * s.hh : s.axy * s.hw + s.ayy * s.hh;
      c = ((i == 0) ? s.cx : s.cy) * ONE;
      a0 = c - e; a1 = c + e;
      slo[i] = a0 < a1 ? a0 : a1; shi[i] = a0 < a1 ? a1 : a0;
      e = (i == 0) ? d.axx * d.hw + d.ayx * d.hh : d.axy * d.hw + d.ayy * d.hh;
      c = ((i == 0) ? d.cx : d.cy) * ONE;
      a0 = c - e; a1 = c + e;
      dlo[i] = a0 < a1 ? a0 : a1; dhi[i] = a0 < a1 ? a1 : a0;
      ilo[i] = slo[i] > dlo[i] ? slo[i] : dlo[i];
      ihi[i] = shi[i] < dhi[i] ? shi[i] : dhi[i];
    end
    if (s.axx == ONE && s.axy == 0 && d.axx == ONE && d.axy == 0) begin
      if (slo[0] > dhi[0] || shi[0] < dlo[0] || slo[1] > dhi[1] || shi[1] < dlo[1])
        return r;
      ox = ihi[0] - ilo[0];
      oy = ihi[1] - ilo[1];
      if (ox < oy) begin
        depth = ox; nx = s.cx < d.cx ? ONE : -ONE; ny = 0;
      end else begin
        depth = oy; nx = 0; ny = s.cy < d.cy ? ONE : -ONE;
      end
    end else begin
      clx = s.cx - d.cx;
      cly = s.cy - d.cy;
      axx[0] = s.axx; axy[0] = s.axy; axx[1] = s.ayx; axy[1] = s.ayy;
      axx[2] = d.axx; axy[2] = d.axy; axx[3] = d.ayx; axy[3] = d.ayy;
      if (!axis_gap(clx, cly, axx[0], axy[0], s.hw, d, ov[0])) return r;
      if (!axis_gap(clx, cly, axx[1], axy[1], s.hh, d, ov[1])) return r;
      if (!axis_gap(clx, cly, axx[2], axy[2], d.hw, s, ov[2])) return r;
      if (!axis_gap(clx, cly, axx[3], axy[3], d.hh, s, ov[3])) return r;
      best = 0;
      for (int i = 1; i < 4; i++)
        if (ov[i] < ov[best]) best = i;
      depth = ov[best];
      nx = axx[best];
      ny = axy[best];
      if (-(nx * clx + ny * cly) < 0) begin
        nx = -nx; ny = -ny;
      end
    end
    r.hit = 1'b1;
    r.depth = HW'(clampv(fl(depth, FB), 0, DEPTH_MAX));
    r.normal_x = R'(nx);
    r.normal_y = R'(ny);
    r.contact_x = W'(clampv(fl(ilo[0] + ihi[0], FB + 1), CMIN, CMAX));
    r.contact_y = W'(clampv(fl(ilo[1] + ihi[1], FB + 1), CMIN, CMAX));
    return r;
  endfunction

  task automatic send_pair(box_t sb, box_t db);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IBW'({db, sb});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_hits.push_back(predict_contact(sb, db));
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic box_t make_box(longint cx, longint cy, longint c, longint s,
                                    longint hw, longint hh);
    box_t b;
    b.cx = W'(cx); b.cy = W'(cy); b.cs = R'(c); b.sn = R'(s);
    b.hw = HW'(hw); b.hh = HW'(hh);
    return b;
  endfunction

  function automatic longint rand_rot();
    case ($urandom_range(0, 5))
      0: return ONE;
      1: return -ONE;
      2: return 0;
      3: return 46341;
      4: return -46341;
      default: return longint'($signed(R'($urandom())));
    endcase
  endfunction

  function automatic box_t rand_box(bit aligned, bit near);
    box_t b;
    longint c, s, a;
    b = box_t'((2 * HW + 2 * R + 2 * W)'({$urandom(), $urandom(), $urandom(),
                                         $urandom(), $urandom(), $urandom()}));
    if (aligned) begin
      b.cs = R'(ONE); b.sn = '0;
    end else if ($urandom_range(0, 2) != 0) begin
      a = $urandom_range(0, 65536);
      c = $urandom_range(0, 1) ? a : -a;
      s = $urandom_range(0, 1) ? 65536 - a : a - 65536;
      b.cs = R'(c); b.sn = R'(s);
    end else begin
      b.cs = R'(rand_rot()); b.sn = R'(rand_rot());
    end
    if (near) begin
      b.cx = W'(longint'($signed(32'($urandom_range(0, 2000000)))) - 1000000);
      b.cy = W'(longint'($signed(32'($urandom_range(0, 2000000)))) - 1000000);
      b.hw = HW'($urandom_range(0, 1500000));
      b.hh = HW'($urandom_range(0, 1500000));
    end
    return b;
  endfunction

  task automatic test_directed;
    longint big;
    big = DEPTH_MAX;
    send_pair(make_box(0, 0, ONE, 0, ONE, ONE), make_box(2 * ONE, 0, ONE, 0, ONE, ONE));
    send_pair(make_box(0, 0, ONE, 0, ONE, ONE), make_box(3 * ONE, 0, ONE, 0, ONE, ONE));
    send_pair(make_box(0, 0, ONE, 0, 2 * ONE, ONE), make_box(ONE, ONE, ONE, 0, ONE, ONE));
    send_pair(make_box(5, 5, ONE, 0, ONE, ONE), make_box(5, 5, ONE, 0, ONE, ONE));
    send_pair(make_box(0, 0, ONE, 0, ONE, 3 * ONE), make_box(ONE, 0, ONE, 0, ONE, ONE));
    send_pair(make_box(0, 0, ONE, 0, 0, 0), make_box(0, 0, ONE, 0, 0, 0));
    send_pair(make_box(0, 0, 46341, 46341, ONE, ONE), make_box(ONE, 0, ONE, 0, ONE, ONE));
    send_pair(make_box(0, 0, 0, ONE, ONE, ONE), make_box(2 * ONE, 0, 0, ONE, ONE, ONE));
    send_pair(make_box(0, 0, -ONE, 0, ONE, ONE), make_box(ONE, ONE, 0, -ONE, ONE, ONE));
    send_pair(make_box(CMAX, CMAX, ONE, 0, big, big),
              make_box(CMIN, CMIN, ONE, 0, big, big));
    send_pair(make_box(CMAX, CMIN, -ONE, 0, big, big),
              make_box(CMIN, CMAX, 0, ONE, big, big));
    send_pair(make_box(CMIN, CMAX, 131071, -131072, big, 0),
              make_box(CMAX, CMIN, -131072, 131071, 0, big));
    send_pair(make_box(0, 0, 2 * ONE, 0, ONE, ONE), make_box(ONE, 0, ONE, ONE, ONE, ONE));
    send_pair(make_box(0, 0, ONE, 0, ONE, ONE), make_box(10 * ONE, 0, 0, ONE, ONE, ONE));
    send_pair(make_box(ONE, ONE, 0, 0, ONE, ONE), make_box(0, 0, 0, 0, ONE, ONE));
    send_pair(make_box(-1, -1, 0, 0, big, big), make_box(0, 0, ONE, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int n);
    bit al, nr;
    for (int i = 0; i < n; i++) begin
      al = $urandom_range(0, 2) == 0;
      nr = $urandom_range(0, 9) != 0;
      send_pair(rand_box(al, nr), rand_box(al, nr));
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_off <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
      end
      test_random(40);
    join
  endtask

  always @(posedge clk) begin
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      gap = 0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (gap != 0) begin
      m_tready <= 1'b0;
      gap = gap - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      gap = $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hit_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = hit_t'(m_tdata[OB-1:0]);
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_hits.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: hit %b/%b depth %h/%h n %h,%h/%h,%h c %h,%h/%h,%h",
                       want.hit, got.hit, want.depth, got.depth,
                       want.normal_x, want.normal_y, got.normal_x, got.normal_y,
                       want.contact_x, want.contact_y, got.contact_x, got.contact_y);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(400);
    quiet = 1;
    test_random(100);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    wait (!rst);
    while (idle_cycles < WATCHDOG) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### sim.f
sv/bbc_pkg.sv
sv/bbc_ext.sv
sv/box_box_collision_2d_top.sv
dv/testbench.sv
